// ===== src/gbcs_pkg.sv =====
// shared constants, codes and handshake structs for the gap buffer cursor store
// no dependencies
`default_nettype none
package gbcs_pkg;

    localparam int CAPACITY = 1 << 10;
    localparam int WINDOW   = 10;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int LEN_W  = $clog2(WINDOW + 1);
    localparam int CHAR_W = 8;

    // input beat layout
    localparam int CMD_LSB  = 0;
    localparam int CHAR_LSB = 2;
    localparam int CNT_LSB  = CHAR_LSB + CHAR_W;
    localparam int IN_BITS  = CNT_LSB + CNT_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;

    // output beat layout
    localparam int STAT_LSB = 0;
    localparam int AMT_LSB  = 1;
    localparam int WIN_LSB  = AMT_LSB + CNT_W;
    localparam int OUT_BITS = WIN_LSB + CHAR_W * WINDOW;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LEFT   = 2'd2,
        CMD_RIGHT  = 2'd3
    } cmd_e_t;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic load;
        logic exec;
        logic move_rd;
        logic move_wr;
        logic win_init;
        logic win_rd;
        logic win_cap;
        logic publish;
    } ctl_cmd_t;

    typedef struct packed {
        cmd_e_t op;
        logic   move_none;
        logic   n_one;
        logic   len_zero;
        logic   win_last;
        logic   out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/gbcs_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module gbcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== src/gbcs_ctrl.sv =====
// command sequencer for the gap buffer cursor store
// depends on gbcs_pkg
`default_nettype none
module gbcs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire gbcs_pkg::dp_stat_t stat,
    output gbcs_pkg::ctl_cmd_t      cmd
);
    import gbcs_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_EXEC     = 8'b0000_0010,
        ST_MOVE_RD  = 8'b0000_0100,
        ST_MOVE_WR  = 8'b0000_1000,
        ST_WIN_INIT = 8'b0001_0000,
        ST_WIN_RD   = 8'b0010_0000,
        ST_WIN_CAP  = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.op == CMD_INSERT || stat.op == CMD_DELETE)
                begin
                    state_next = ST_DONE;
                end
                else if (stat.move_none)
                begin
                    state_next = ST_WIN_INIT;
                end
                else
                begin
                    state_next = ST_MOVE_RD;
                end
            end
            ST_MOVE_RD:
            begin
                cmd.move_rd = 1'b1;
                state_next  = ST_MOVE_WR;
            end
            ST_MOVE_WR:
            begin
                cmd.move_wr = 1'b1;
                state_next  = stat.n_one ? ST_WIN_INIT : ST_MOVE_RD;
            end
            ST_WIN_INIT:
            begin
                cmd.win_init = 1'b1;
                state_next   = stat.len_zero ? ST_DONE : ST_WIN_RD;
            end
            ST_WIN_RD:
            begin
                cmd.win_rd = 1'b1;
                state_next = ST_WIN_CAP;
            end
            ST_WIN_CAP:
            begin
                cmd.win_cap = 1'b1;
                state_next  = stat.win_last ? ST_DONE : ST_WIN_RD;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/gbcs_dp.sv =====
// datapath: cursor counts, text ram, window capture and result register
// depends on gbcs_pkg and gbcs_ram
`default_nettype none
module gbcs_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gbcs_pkg::ctl_cmd_t            cmd,
    output gbcs_pkg::dp_stat_t                 stat,
    input  wire logic [gbcs_pkg::IN_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [gbcs_pkg::OUT_W-1:0]    m_tdata
);
    import gbcs_pkg::*;

    cmd_e_t            op_reg, op_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  left_count_reg, left_count_next;
    logic [CNT_W-1:0]  right_count_reg, right_count_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [CHAR_W-1:0] win_reg [WINDOW];
    logic [CHAR_W-1:0] win_next [WINDOW];
    logic              status_reg, status_next;
    logic [CNT_W-1:0]  amount_reg, amount_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;

    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [CHAR_W-1:0] wr_data, rd_data;

    logic [CNT_W-1:0]  del_n, move_n;
    logic [LEN_W-1:0]  win_len;
    logic              full;

    gbcs_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CAPACITY)
    ) u_text_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        del_n  = (cnt_reg < left_count_reg) ? cnt_reg : left_count_reg;
        move_n = (op_reg == CMD_LEFT) ? del_n
               : ((cnt_reg < right_count_reg) ? cnt_reg : right_count_reg);
        win_len = (left_count_reg < CNT_W'(WINDOW)) ? left_count_reg[LEN_W-1:0]
                                                    : LEN_W'(WINDOW);
        full = ({1'b0, left_count_reg} + {1'b0, right_count_reg})
               >= (CNT_W + 1)'(CAPACITY);
    end

    always_comb
    begin
        stat.op        = op_reg;
        stat.move_none = (move_n == '0);
        stat.n_one     = (n_reg == CNT_W'(1));
        stat.len_zero  = (win_len == '0);
        stat.win_last  = (idx_reg == len_reg - LEN_W'(1));
        stat.out_free  = !out_valid_reg || m_tready;
    end

    always_comb
    begin
        op_next          = op_reg;
        ch_next          = ch_reg;
        cnt_next         = cnt_reg;
        left_count_next  = left_count_reg;
        right_count_next = right_count_reg;
        n_next           = n_reg;
        len_next         = len_reg;
        idx_next         = idx_reg;
        win_next         = win_reg;
        status_next      = status_reg;
        amount_next      = amount_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        wr_en            = 1'b0;
        wr_addr          = left_count_reg[ADDR_W-1:0];
        wr_data          = ch_reg;
        rd_en            = 1'b0;
        rd_addr          = left_count_reg[ADDR_W-1:0];

        if (cmd.load)
        begin
            op_next  = cmd_e_t'(s_tdata[CMD_LSB +: 2]);
            ch_next  = s_tdata[CHAR_LSB +: CHAR_W];
            cnt_next = s_tdata[CNT_LSB +: CNT_W];
        end

        if (cmd.exec)
        begin
            for (int k = 0; k < WINDOW; k++)
            begin
                win_next[k] = '0;
            end
            status_next = STATUS_OK;
            amount_next = '0;
            case (op_reg)
                CMD_INSERT:
                begin
                    if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        wr_en           = 1'b1;
                        left_count_next = left_count_reg + CNT_W'(1);
                        amount_next     = CNT_W'(1);
                    end
                end
                CMD_DELETE:
                begin
                    left_count_next = left_count_reg - del_n;
                    amount_next     = del_n;
                end
                default:
                begin
                    n_next = move_n;
                end
            endcase
        end

        if (cmd.move_rd)
        begin
            rd_en = 1'b1;
            if (op_reg == CMD_LEFT)
            begin
                rd_addr = left_count_reg[ADDR_W-1:0] - ADDR_W'(1);
            end
            else
            begin
                // first byte of the right text sits at capacity - right_count
                rd_addr = ADDR_W'(0) - right_count_reg[ADDR_W-1:0];
            end
        end

        if (cmd.move_wr)
        begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            n_next  = n_reg - CNT_W'(1);
            if (op_reg == CMD_LEFT)
            begin
                // capacity - right_count - 1
                wr_addr          = ~right_count_reg[ADDR_W-1:0];
                left_count_next  = left_count_reg - CNT_W'(1);
                right_count_next = right_count_reg + CNT_W'(1);
            end
            else
            begin
                wr_addr          = left_count_reg[ADDR_W-1:0];
                left_count_next  = left_count_reg + CNT_W'(1);
                right_count_next = right_count_reg - CNT_W'(1);
            end
        end

        if (cmd.win_init)
        begin
            len_next    = win_len;
            idx_next    = '0;
            amount_next = CNT_W'(win_len);
        end

        if (cmd.win_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = left_count_reg[ADDR_W-1:0] - ADDR_W'(len_reg) + ADDR_W'(idx_reg);
        end

        if (cmd.win_cap)
        begin
            for (int k = 0; k < WINDOW; k++)
            begin
                if (idx_reg == LEN_W'(k))
                begin
                    win_next[k] = rd_data;
                end
            end
            idx_next = idx_reg + LEN_W'(1);
        end

        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_data_next[STAT_LSB]             = status_reg;
            out_data_next[AMT_LSB +: CNT_W]     = amount_reg;
            for (int k = 0; k < WINDOW; k++)
            begin
                out_data_next[WIN_LSB + CHAR_W * k +: CHAR_W] = win_reg[k];
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_count_reg  <= '0;
            right_count_reg <= '0;
            n_reg           <= '0;
            len_reg         <= '0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            left_count_reg  <= left_count_next;
            right_count_reg <= right_count_next;
            n_reg           <= n_next;
            len_reg         <= len_next;
            idx_reg         <= idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ch_reg       <= ch_next;
        cnt_reg      <= cnt_next;
        win_reg      <= win_next;
        status_reg   <= status_next;
        amount_reg   <= amount_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    a_counts_fit: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, left_count_reg} + {1'b0, right_count_reg}) <= (CNT_W + 1)'(CAPACITY))
        else $error("left and right text exceed capacity");

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish && out_valid_reg |-> m_tready)
        else $error("result overwritten before it was taken");

    a_move_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move_wr |-> n_reg != '0)
        else $error("byte moved with no moves left");

    a_win_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.win_cap |-> idx_reg < len_reg)
        else $error("window capture past window length");
`endif

endmodule
`default_nettype wire

// ===== src/gap_buffer_cursor_store_unit.sv =====
// top level: joins gbcs_ctrl and gbcs_dp, depends on gbcs_pkg
// sequence: insert and delete run the execute state then the done state; a move of n bytes
// with window length w runs execute, n read/write pairs, window init, w read/capture
// pairs and done, one read then one write or capture per byte on the registered-read text ram
// flow: one command in flight; the next beat is taken only once the result is loaded into
// the output register, and the done state waits while an earlier result is not yet taken
// reset clears both cursor counts and the result valid; the text ram is not cleared
`default_nettype none
module gap_buffer_cursor_store_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // command[1:0], char_in[9:2], count[20:10], zero pad
    input  wire logic [gbcs_pkg::IN_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // status[0], amount[11:1], win0[19:12] .. win9[91:84], zero pad
    output logic      [gbcs_pkg::OUT_W-1:0] m_tdata
);
    import gbcs_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    gbcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbcs_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire
